/* sv/tasr_pkg.sv */
// Package with shared types and constants for the tensor axis sum reduction block.
package tasr_pkg;

  // Field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned SumW   = 48;
  localparam int unsigned DestW  = 26;
  localparam int unsigned OuterW = 16;
  localparam int unsigned AxisW  = 16;
  localparam int unsigned SlotW  = 10;
  localparam int unsigned CfgW   = 17;
  localparam int unsigned CfgIdxW = 2;

  // Partial sum memory depth (one entry per inner position)
  localparam int unsigned MaxInner = 1024;

  // Queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegOuterCount = 2'd0;
  localparam logic [CfgIdxW-1:0] RegReduceLen  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegInnerCount = 2'd2;

  // Clamped counts, stored as count minus one
  typedef struct packed {
    logic [OuterW-1:0] outer_max;
    logic [AxisW-1:0]  axis_max;
    logic [SlotW-1:0]  inner_max;
  } cfg_t;

  // One classified word on its way to the accumulator
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [SlotW-1:0]         slot;
    logic                     first;
    logic                     emit;
    logic [DestW-1:0]         dest;
    logic                     last;
  } op_t;

endpackage

/* sv/tasr_front.sv */
// Front end: configuration registers, tensor position counters and word classification.
module tasr_front
  import tasr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgW-1:0]          cfg_data_i,
  input  logic                     in_valid_i,
  input  logic signed [ValueW-1:0] in_value_i,
  output logic                     in_ready_o,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output op_t                      q_op_o,
  output cfg_t                     cfg_o
);

  cfg_t              cfg_q, cfg_d;
  logic [SlotW-1:0]  inner_q, inner_d;
  logic [AxisW-1:0]  axis_q, axis_d;
  logic [OuterW-1:0] outer_q, outer_d;
  logic [DestW-1:0]  base_q, base_d;
  logic              accept;
  logic              restart;
  logic              inner_wrap, axis_wrap, outer_wrap;
  logic [DestW-1:0]  stride;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;
  assign cfg_o      = cfg_q;

  assign inner_wrap = (inner_q == cfg_q.inner_max);
  assign axis_wrap  = (axis_q == cfg_q.axis_max);
  assign outer_wrap = (outer_q == cfg_q.outer_max);
  assign stride     = DestW'(cfg_q.inner_max) + DestW'(1);

  // Classify the incoming word
  always_comb begin
    q_op_o.value = in_value_i;
    q_op_o.slot  = inner_q;
    q_op_o.first = (axis_q == '0);
    q_op_o.emit  = axis_wrap;
    q_op_o.dest  = base_q + DestW'(inner_q);
    q_op_o.last  = axis_wrap && outer_wrap && inner_wrap;
  end

  // Clamp register writes; a count of zero acts as one
  always_comb begin
    cfg_d   = cfg_q;
    restart = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        RegOuterCount: begin
          restart = 1'b1;
          if (cfg_data_i == '0) cfg_d.outer_max = '0;
          else if (cfg_data_i[CfgW-1]) cfg_d.outer_max = '1;
          else cfg_d.outer_max = OuterW'(cfg_data_i - CfgW'(1));
        end
        RegReduceLen: begin
          restart = 1'b1;
          if (cfg_data_i == '0) cfg_d.axis_max = '0;
          else if (cfg_data_i[CfgW-1]) cfg_d.axis_max = '1;
          else cfg_d.axis_max = AxisW'(cfg_data_i - CfgW'(1));
        end
        RegInnerCount: begin
          // The inner count register holds the low 11 bits only
          restart = 1'b1;
          if (cfg_data_i[SlotW:0] == '0) cfg_d.inner_max = '0;
          else if (cfg_data_i[SlotW:0] > (SlotW+1)'(MaxInner))
            cfg_d.inner_max = SlotW'(MaxInner - 1);
          else cfg_d.inner_max = SlotW'(cfg_data_i[SlotW:0] - (SlotW+1)'(1));
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  // Advance positions, inner fastest
  always_comb begin
    inner_d = inner_q;
    axis_d  = axis_q;
    outer_d = outer_q;
    base_d  = base_q;
    if (restart) begin
      inner_d = '0;
      axis_d  = '0;
      outer_d = '0;
      base_d  = '0;
    end else if (accept) begin
      if (!inner_wrap) begin
        inner_d = inner_q + SlotW'(1);
      end else begin
        inner_d = '0;
        if (!axis_wrap) begin
          axis_d = axis_q + AxisW'(1);
        end else begin
          axis_d = '0;
          if (outer_wrap) begin
            outer_d = '0;
            base_d  = '0;
          end else begin
            outer_d = outer_q + OuterW'(1);
            base_d  = base_q + stride;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '0;
      inner_q <= '0;
      axis_q  <= '0;
      outer_q <= '0;
      base_q  <= '0;
    end else begin
      cfg_q   <= cfg_d;
      inner_q <= inner_d;
      axis_q  <= axis_d;
      outer_q <= outer_d;
      base_q  <= base_d;
    end
  end

endmodule

/* sv/tasr_queue.sv */
// Short queue of classified words between front end and accumulator.
module tasr_queue
  import tasr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  op_t              push_op_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output op_t              head_o,
  output logic [QCntW-1:0] count_o
);

  op_t              entries_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == QCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign count_o = count_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Track fill level
  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) count_d = count_q + QCntW'(1);
    else if (do_pop && !do_push) count_d = count_q - QCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= push_op_i;
  end

endmodule

/* sv/tasr_back.sv */
// Back end: partial sum memory with read-modify-write, forwarding and result register.
module tasr_back
  import tasr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  op_t              q_head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [SumW-1:0]  out_sum_o,
  output logic [DestW-1:0] out_dest_o,
  output logic             out_last_o
);

  logic [SumW-1:0]  mem_q [MaxInner];
  logic [SumW-1:0]  rd_q;
  op_t              s1_q;
  logic             s1_valid_q;
  logic [SlotW-1:0] fwd_slot_q;
  logic [SumW-1:0]  fwd_sum_q;
  logic             fwd_valid_q;
  logic             out_valid_q;
  logic [SumW-1:0]  out_sum_q;
  logic [DestW-1:0] out_dest_q;
  logic             out_last_q;
  logic             adv;
  logic             wr_en;
  logic [SumW-1:0]  prev_sum;
  logic [SumW-1:0]  new_sum;
  logic [SumW-1:0]  value_ext;

  // Whole back end moves together when the result register can take a word
  assign adv     = !out_valid_q || out_ready_i;
  assign q_pop_o = adv && q_valid_i;
  assign wr_en   = adv && s1_valid_q;

  // Latest write to the same slot wins over the memory read
  assign value_ext = {{(SumW-ValueW){s1_q.value[ValueW-1]}}, s1_q.value};
  assign prev_sum  = (fwd_valid_q && fwd_slot_q == s1_q.slot) ? fwd_sum_q : rd_q;
  assign new_sum   = s1_q.first ? value_ext : prev_sum + value_ext;

  // Read the partial sum when a word is popped, write back the updated one
  always_ff @(posedge clk_i) begin
    if (q_pop_o) rd_q <= mem_q[q_head_i.slot];
    if (wr_en)   mem_q[s1_q.slot] <= new_sum;
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) s1_q <= q_head_i;
    if (wr_en) begin
      fwd_slot_q <= s1_q.slot;
      fwd_sum_q  <= new_sum;
    end
    if (wr_en && s1_q.emit) begin
      out_sum_q  <= new_sum;
      out_dest_q <= s1_q.dest;
      out_last_q <= s1_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_q  <= q_valid_i;
        out_valid_q <= s1_valid_q && s1_q.emit;
      end
      if (wr_en) fwd_valid_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_sum_o   = out_sum_q;
  assign out_dest_o  = out_dest_q;
  assign out_last_o  = out_last_q;

endmodule

/* sv/tensor_axis_sum_reduction_top.sv */
// Top level of the tensor axis sum reduction block.
//
//  Channel  | Dir | Signals                                  | Content
//  ---------+-----+------------------------------------------+--------------------------------
//  s_axis   | in  | s_axis_tvalid_i/tready_o/tdata_i[31:0]   | value (signed Q16.16)
//  m_axis   | out | m_axis_tvalid_o/tready_i/tdata_o[79:0]   | sum[47:0], dest_index[73:48]
//           |     | m_axis_tlast_o                           | end of tensor
//  cfg      | in  | cfg_we_i, cfg_index_i[1:0], cfg_data_i   | outer_count, reduce_len,
//           |     |                                          | inner_count
//
// One word per cycle sustained while the result register can take a word; the sum memory is read
// and written in the same cycle, with the last written sum forwarded to cover back-to-back hits.
// A result word is built from its input word through the queue write, the memory read and the
// result register.
// Reset clears counters and control only; the sum memory needs no clearing since the first
// word of each axis run overwrites its slot. A stalled result stops the back end while the
// front keeps taking words until the four-entry queue fills.
module tensor_axis_sum_reduction_top
  import tasr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgW-1:0]        cfg_data_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [ValueW-1:0]      s_axis_tdata_i,   // [31:0] value
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [79:0]            m_axis_tdata_o,   // [47:0] sum, [73:48] dest_index, zero pad
  output logic                   m_axis_tlast_o
);

  op_t              push_op, head_op;
  cfg_t             cfg;
  logic             q_push, q_pop, q_full, q_valid;
  logic [QCntW-1:0] q_count;
  logic [SumW-1:0]  out_sum;
  logic [DestW-1:0] out_dest;

  tasr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_value_i  (s_axis_tdata_i),
    .in_ready_o  (s_axis_tready_o),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_op_o      (push_op),
    .cfg_o       (cfg)
  );

  tasr_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (push_op),
    .pop_i     (q_pop),
    .full_o    (q_full),
    .valid_o   (q_valid),
    .head_o    (head_op),
    .count_o   (q_count)
  );

  tasr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (head_op),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_sum_o   (out_sum),
    .out_dest_o  (out_dest),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'd0, out_dest, out_sum};

  // Queue fill level stays within its depth
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCntW'(QueueDepth))
    else $error("queue count exceeds depth");

  // Input is held off only when the queue is full
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> q_count == QCntW'(QueueDepth))
    else $error("input stalled with queue space left");

  // End-of-tensor result carries the highest flat output index
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      (32'(out_dest) + 32'd1 ==
       (32'(cfg.outer_max) + 32'd1) * (32'(cfg.inner_max) + 32'd1)))
    else $error("last result with wrong output index");

endmodule
